// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers clocked on i_clk, held off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PMX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pmx_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmx_pkg
// shared widths, constants and types of the crossover block
// ---------------------------------------------------------------------------
package pmx_pkg;

    localparam int GENE_W        = 6;
    localparam int GENE_N        = 64;
    localparam int LEN_W         = 7;
    localparam int MAX_GENES_DEF = 64;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [LEN_W-1:0] TOUR_LEN_RST = 7'd64;
    localparam logic [LEN_W-1:0] MIN_LEN      = 7'd2;

    // one loaded gene pair with the set information it belongs to
    typedef struct packed {
        logic [GENE_W-1:0] gene_a;
        logic [GENE_W-1:0] gene_b;
        logic [GENE_W-1:0] pos;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [GENE_W-1:0] seg_s;
        logic [GENE_W-1:0] seg_e;
    } t_fe_item;

    // one child position
    typedef struct packed {
        logic [GENE_W-1:0] pos;
        logic [GENE_W-1:0] gene_a;
        logic [GENE_W-1:0] gene_b;
        logic              err;
        logic              last;
    } t_result;

endpackage

// File: hdl/partially_mapped_crossover.sv
`timescale 1ns / 1ps
// loading: a set of n gene pairs loads at one request per cycle while the queue is not full;
//   the back pops pairs only in its load state and builds the maps after the last pair
// walks: each child position walks its two mapping chains, one map read per step,
//   each walk capped at n steps; segment positions need no walk
// reset: synchronous active-low; length register back to 64, queue and maps empty
// ---------------------------------------------------------------------------
// partially_mapped_crossover
// pmx crossover of two parent permutations streamed in as gene pairs
// ---------------------------------------------------------------------------
module partially_mapped_crossover #(
    parameter int MAX_GENES = pmx_pkg::MAX_GENES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tour length register, written whenever the write enable is high
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // gene pair requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // parent_a_gene, parent_b_gene, cut_start, cut_end (cuts used on first pair only)
    input  logic [23:0] s_axis_tdata,
    // child position results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // position, child_a_gene, child_b_gene, zero pad
    output logic [23:0] m_axis_tdata,
    // chain_error
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int GW = pmx_pkg::GENE_W;

    // front to queue
    logic              fe_push;
    pmx_pkg::t_fe_item fe_item;
    logic              q_full;

    // queue to back
    logic              q_valid;
    pmx_pkg::t_fe_item q_item;
    logic              q_pop;

    // back result register
    pmx_pkg::t_result  res;

    // front: length clamp, cut clamp and ordering, set boundary tagging
    pmx_front #(
        .MAX_GENES (MAX_GENES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_gene_a    (s_axis_tdata[GW-1:0]),
        .i_gene_b    (s_axis_tdata[2*GW-1:GW]),
        .i_cut_s     (s_axis_tdata[3*GW-1:2*GW]),
        .i_cut_e     (s_axis_tdata[4*GW-1:3*GW]),
        .i_q_full    (q_full),
        .o_push      (fe_push),
        .o_item      (fe_item)
    );

    // decoupling queue: front keeps taking pairs while the back is busy, until the queue is full
    pmx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_item  (fe_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // back: parent stores, map build, chain walks, output register
    pmx_back #(
        .MAX_GENES (MAX_GENES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {6'b0, res.gene_b, res.gene_a, res.pos};
    assign m_axis_tuser = res.err;
    assign m_axis_tlast = res.last;

endmodule

// File: hdl/pmx_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmx_front
// takes requests, holds the length register, clamps cuts, tags set ends
// ---------------------------------------------------------------------------
module pmx_front #(
    parameter int MAX_GENES = pmx_pkg::MAX_GENES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pmx_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pmx_pkg::GENE_W-1:0]  i_gene_a,
    input  logic [pmx_pkg::GENE_W-1:0]  i_gene_b,
    input  logic [pmx_pkg::GENE_W-1:0]  i_cut_s,
    input  logic [pmx_pkg::GENE_W-1:0]  i_cut_e,
    input  logic                        i_q_full,
    output logic                        o_push,
    output pmx_pkg::t_fe_item           o_item
);

    localparam int LW = pmx_pkg::LEN_W;
    localparam int GW = pmx_pkg::GENE_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_GENES);

    logic [LW-1:0] r_tour_len, n_tour_len;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic [GW-1:0] r_s, n_s;
    logic [GW-1:0] r_e, n_e;

    logic [LW-1:0] len_c, lm1, len_use;
    logic [GW-1:0] s_cl, e_cl, s_c, e_c, s_use, e_use;
    logic          first, last;

    always_comb begin
        len_c = r_tour_len;
        if (len_c < pmx_pkg::MIN_LEN) begin
            len_c = pmx_pkg::MIN_LEN;
        end
        if (len_c > MAX_LEN) begin
            len_c = MAX_LEN;
        end
        lm1  = len_c - LW'(1);
        s_cl = ({1'b0, i_cut_s} > lm1) ? lm1[GW-1:0] : i_cut_s;
        e_cl = ({1'b0, i_cut_e} > lm1) ? lm1[GW-1:0] : i_cut_e;
        // reversed cuts are put into order
        s_c  = (s_cl > e_cl) ? e_cl : s_cl;
        e_c  = (s_cl > e_cl) ? s_cl : e_cl;

        first   = (r_cnt == '0);
        len_use = first ? len_c : r_len;
        s_use   = first ? s_c : r_s;
        e_use   = first ? e_c : r_e;
        last    = ((r_cnt + LW'(1)) == len_use);
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.gene_a = i_gene_a;
        o_item.gene_b = i_gene_b;
        o_item.pos    = r_cnt[GW-1:0];
        o_item.last   = last;
        o_item.len    = len_use;
        o_item.seg_s  = s_use;
        o_item.seg_e  = e_use;
    end

    always_comb begin
        n_tour_len = r_tour_len;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_s        = r_s;
        n_e        = r_e;
        if (i_cfg_we) begin
            n_tour_len = i_cfg_wdata;
        end
        if (o_push) begin
            n_len = len_use;
            n_s   = s_use;
            n_e   = e_use;
            n_cnt = last ? '0 : r_cnt + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tour_len <= pmx_pkg::TOUR_LEN_RST;
            r_cnt      <= '0;
            r_len      <= pmx_pkg::TOUR_LEN_RST;
            r_s        <= '0;
            r_e        <= '0;
        end else begin
            r_tour_len <= n_tour_len;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_s        <= n_s;
            r_e        <= n_e;
        end
    end

endmodule

// File: hdl/pmx_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmx_queue
// short fifo of loaded gene pairs between front and back
// ---------------------------------------------------------------------------
module pmx_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pmx_pkg::t_fe_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output pmx_pkg::t_fe_item o_item,
    input  logic              i_pop
);

    localparam int DEPTH = pmx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmx_pkg::t_fe_item r_buf [DEPTH];

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hdl/pmx_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmx_back
// parent stores, map build over the segment, chain walks and child output
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmx_back #(
    parameter int MAX_GENES = pmx_pkg::MAX_GENES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  pmx_pkg::t_fe_item i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pmx_pkg::t_result  o_out
);

    localparam int GW = pmx_pkg::GENE_W;
    localparam int LW = pmx_pkg::LEN_W;
    localparam int GN = pmx_pkg::GENE_N;
    localparam int PW = $clog2(MAX_GENES);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_BUILD = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_WALK  = 5'b10000
    } t_state;

    t_state r_st, n_st;

    logic [GW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_len, n_len;
    logic [GW-1:0] r_s, n_s;
    logic [GW-1:0] r_e, n_e;
    logic          r_wr_pend, n_wr_pend;
    logic          r_first, n_first;
    logic          r_a_map, n_a_map;
    logic          r_b_map, n_b_map;
    logic [GW-1:0] r_ga, n_ga;
    logic [GW-1:0] r_gb, n_gb;
    logic [LW-1:0] r_ka, n_ka;
    logic [LW-1:0] r_kb, n_kb;
    logic [GN-1:0] r_vld_ba, n_vld_ba;
    logic [GN-1:0] r_vld_ab, n_vld_ab;
    logic          r_out_valid, n_out_valid;
    pmx_pkg::t_result r_out, n_out;

    logic [GW-1:0] mem_pa [MAX_GENES];
    logic [GW-1:0] mem_pb [MAX_GENES];
    logic [GW-1:0] mem_ba [GN];
    logic [GW-1:0] mem_ab [GN];
    logic [GW-1:0] r_rd_pa, r_rd_pb, r_rd_ba, r_rd_ab;

    logic          pop, in_seg, walking, va, vb, cont_a, cont_b, done, out_free, emit;
    logic          is_last;
    logic [GW-1:0] cur_a, cur_b;

    always_comb begin
        pop      = i_q_valid && (r_st == ST_LOAD);
        in_seg   = (r_idx >= r_s) && (r_idx <= r_e);
        // chain head comes from the parent read, then from the map reads
        cur_a    = r_first ? r_rd_pa : (r_a_map ? r_rd_ba : r_ga);
        cur_b    = r_first ? r_rd_pb : (r_b_map ? r_rd_ab : r_gb);
        va       = r_vld_ba[cur_a];
        vb       = r_vld_ab[cur_b];
        walking  = (r_st == ST_WALK);
        cont_a   = walking && !in_seg && va && (r_ka < r_len);
        cont_b   = walking && !in_seg && vb && (r_kb < r_len);
        done     = walking && !cont_a && !cont_b;
        out_free = !r_out_valid || i_out_ready;
        emit     = done && out_free;
        is_last  = (({1'b0, r_idx} + LW'(1)) == r_len);
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_st        = r_st;
        n_idx       = r_idx;
        n_len       = r_len;
        n_s         = r_s;
        n_e         = r_e;
        n_wr_pend   = 1'b0;
        n_first     = r_first;
        n_a_map     = r_a_map;
        n_b_map     = r_b_map;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_ka        = r_ka;
        n_kb        = r_kb;
        n_vld_ba    = r_vld_ba;
        n_vld_ab    = r_vld_ab;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        case (r_st)
            ST_LOAD: begin
                if (pop && i_q_item.last) begin
                    n_len    = i_q_item.len;
                    n_s      = i_q_item.seg_s;
                    n_e      = i_q_item.seg_e;
                    n_idx    = i_q_item.seg_s;
                    n_vld_ba = '0;
                    n_vld_ab = '0;
                    n_st     = ST_BUILD;
                end
            end
            ST_BUILD: begin
                n_wr_pend = 1'b1;
                if (r_idx == r_e) begin
                    n_st = ST_DRAIN;
                end else begin
                    n_idx = r_idx + GW'(1);
                end
            end
            ST_DRAIN: begin
                n_idx = '0;
                n_st  = ST_FETCH;
            end
            ST_FETCH: begin
                n_first = 1'b1;
                n_a_map = 1'b0;
                n_b_map = 1'b0;
                n_ka    = '0;
                n_kb    = '0;
                n_st    = ST_WALK;
            end
            ST_WALK: begin
                n_first = 1'b0;
                n_ga    = cur_a;
                n_gb    = cur_b;
                n_a_map = cont_a;
                n_b_map = cont_b;
                n_ka    = r_ka + LW'(cont_a);
                n_kb    = r_kb + LW'(cont_b);
                if (emit) begin
                    if (is_last) begin
                        n_st = ST_LOAD;
                    end else begin
                        n_idx = r_idx + GW'(1);
                        n_st  = ST_FETCH;
                    end
                end
            end
            default: begin
                n_st = ST_LOAD;
            end
        endcase

        // later segment positions overwrite earlier keys
        if (r_wr_pend) begin
            n_vld_ba[r_rd_pb] = 1'b1;
            n_vld_ab[r_rd_pa] = 1'b1;
        end

        if (emit) begin
            n_out_valid  = 1'b1;
            n_out.pos    = r_idx;
            n_out.gene_a = in_seg ? r_rd_pb : cur_a;
            n_out.gene_b = in_seg ? r_rd_pa : cur_b;
            n_out.err    = !in_seg && (va || vb);
            n_out.last   = is_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // parent stores
    always_ff @(posedge i_clk) begin
        if (pop) begin
            mem_pa[i_q_item.pos[PW-1:0]] <= i_q_item.gene_a;
            mem_pb[i_q_item.pos[PW-1:0]] <= i_q_item.gene_b;
        end
        r_rd_pa <= mem_pa[r_idx[PW-1:0]];
        r_rd_pb <= mem_pb[r_idx[PW-1:0]];
    end

    // mapping tables
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            mem_ba[r_rd_pb] <= r_rd_pa;
            mem_ab[r_rd_pa] <= r_rd_pb;
        end
        r_rd_ba <= mem_ba[cur_a];
        r_rd_ab <= mem_ab[cur_b];
    end

    always_ff @(posedge i_clk) begin
        r_ga  <= n_ga;
        r_gb  <= n_gb;
        r_ka  <= n_ka;
        r_kb  <= n_kb;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_LOAD;
            r_idx       <= '0;
            r_len       <= pmx_pkg::TOUR_LEN_RST;
            r_s         <= '0;
            r_e         <= '0;
            r_wr_pend   <= 1'b0;
            r_first     <= 1'b0;
            r_a_map     <= 1'b0;
            r_b_map     <= 1'b0;
            r_vld_ba    <= '0;
            r_vld_ab    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_s         <= n_s;
            r_e         <= n_e;
            r_wr_pend   <= n_wr_pend;
            r_first     <= n_first;
            r_a_map     <= n_a_map;
            r_b_map     <= n_b_map;
            r_vld_ba    <= n_vld_ba;
            r_vld_ab    <= n_vld_ab;
            r_out_valid <= n_out_valid;
        end
    end

    `PMX_ASSERT_IMP(a_map_wr_phase, r_wr_pend, (r_st == ST_BUILD) || (r_st == ST_DRAIN), "map write outside build")
    `PMX_ASSERT_IMP(a_seg_order, r_st == ST_BUILD, (r_s <= r_idx) && (r_idx <= r_e), "segment walk out of order")
    `PMX_ASSERT_IMP(a_fetch_range, r_st == ST_FETCH, {1'b0, r_idx} < r_len, "position beyond set length")
    `PMX_ASSERT_IMP(a_walk_cap, r_st == ST_WALK, (r_ka <= r_len) && (r_kb <= r_len), "chain walk past cap")
    `PMX_ASSERT_NXT(a_map_clear, pop && i_q_item.last, (r_vld_ba == '0) && (r_vld_ab == '0), "maps not cleared for set")

endmodule
